FILE: rtl/core/mbvd_pkg.sv
// Shared types, constants and lookup functions of the measuring block value decoder.
package mbvd_pkg;

    localparam int QW = 28;   // quotient bits of the divider
    localparam int MW = 38;   // dividend bits
    localparam int DW = 17;   // divisor bits after the rounding doubling

    localparam logic [2:0] KIND_NUM   = 3'd0;
    localparam logic [2:0] KIND_TEXT  = 3'd1;
    localparam logic [2:0] KIND_BITS  = 3'd2;
    localparam logic [2:0] KIND_CHR2  = 3'd3;
    localparam logic [2:0] KIND_CHRQ  = 3'd4;
    localparam logic [2:0] KIND_HM    = 3'd5;
    localparam logic [2:0] KIND_UNK   = 3'd6;

    localparam logic [3:0] TXT_RAW  = 4'd0;
    localparam logic [3:0] TXT_COLD = 4'd14;
    localparam logic [3:0] TXT_WARM = 4'd15;

    localparam logic [5:0] UNIT_HM = 6'd23;

    localparam logic [7:0] FT_1 = 8'd1,   FT_2 = 8'd2,   FT_3 = 8'd3,   FT_4 = 8'd4;
    localparam logic [7:0] FT_5 = 8'd5,   FT_6 = 8'd6,   FT_7 = 8'd7,   FT_8 = 8'd8;
    localparam logic [7:0] FT_9 = 8'd9,   FT_10 = 8'd10, FT_11 = 8'd11, FT_12 = 8'd12;
    localparam logic [7:0] FT_13 = 8'd13, FT_14 = 8'd14, FT_15 = 8'd15, FT_16 = 8'd16;
    localparam logic [7:0] FT_17 = 8'd17, FT_18 = 8'd18, FT_19 = 8'd19, FT_20 = 8'd20;
    localparam logic [7:0] FT_21 = 8'd21, FT_22 = 8'd22, FT_23 = 8'd23, FT_24 = 8'd24;
    localparam logic [7:0] FT_25 = 8'd25, FT_26 = 8'd26, FT_27 = 8'd27, FT_28 = 8'd28;
    localparam logic [7:0] FT_30 = 8'd30, FT_31 = 8'd31, FT_33 = 8'd33, FT_34 = 8'd34;
    localparam logic [7:0] FT_35 = 8'd35, FT_36 = 8'd36, FT_37 = 8'd37, FT_38 = 8'd38;
    localparam logic [7:0] FT_39 = 8'd39, FT_40 = 8'd40, FT_41 = 8'd41, FT_42 = 8'd42;
    localparam logic [7:0] FT_43 = 8'd43, FT_44 = 8'd44, FT_45 = 8'd45, FT_46 = 8'd46;
    localparam logic [7:0] FT_47 = 8'd47, FT_48 = 8'd48, FT_49 = 8'd49, FT_50 = 8'd50;
    localparam logic [7:0] FT_51 = 8'd51, FT_52 = 8'd52, FT_53 = 8'd53, FT_54 = 8'd54;
    localparam logic [7:0] FT_55 = 8'd55, FT_56 = 8'd56, FT_57 = 8'd57, FT_59 = 8'd59;
    localparam logic [7:0] FT_60 = 8'd60, FT_61 = 8'd61, FT_62 = 8'd62, FT_63 = 8'd63;
    localparam logic [7:0] FT_64 = 8'd64, FT_65 = 8'd65, FT_66 = 8'd66, FT_67 = 8'd67;
    localparam logic [7:0] FT_68 = 8'd68, FT_69 = 8'd69, FT_70 = 8'd70;

    typedef struct packed {
        logic [2:0]        kind;
        logic [1:0]        dec;
        logic [5:0]        unit;
        logic [3:0]        text;
        logic [7:0]        a;
        logic [7:0]        b;
        logic              neg;
        logic              m1000;
        logic signed [8:0] offs;
    } t_side;

    function automatic logic [5:0] unit_of(input logic [7:0] f);
        case (f)
            FT_1: unit_of = 6'd1;
            FT_2, FT_20, FT_23, FT_33: unit_of = 6'd2;
            FT_3, FT_9, FT_27, FT_34, FT_67: unit_of = 6'd3;
            FT_5, FT_31: unit_of = 6'd4;
            FT_6, FT_21, FT_43, FT_66: unit_of = 6'd5;
            FT_7: unit_of = 6'd6;
            FT_12, FT_64: unit_of = 6'd7;
            FT_13, FT_65: unit_of = 6'd8;
            FT_14, FT_69: unit_of = 6'd9;
            FT_15, FT_22, FT_47: unit_of = 6'd10;
            FT_16: unit_of = 6'd11;
            FT_18, FT_50: unit_of = 6'd12;
            FT_19: unit_of = 6'd13;
            FT_24, FT_40: unit_of = 6'd14;
            FT_25, FT_53: unit_of = 6'd15;
            FT_26: unit_of = 6'd16;
            FT_35: unit_of = 6'd17;
            FT_36: unit_of = 6'd18;
            FT_37: unit_of = 6'd19;
            FT_30, FT_38, FT_46: unit_of = 6'd20;
            FT_41: unit_of = 6'd21;
            FT_42: unit_of = 6'd22;
            FT_44: unit_of = UNIT_HM;
            FT_39, FT_49, FT_51: unit_of = 6'd24;
            FT_52: unit_of = 6'd25;
            FT_54: unit_of = 6'd26;
            FT_55: unit_of = 6'd27;
            FT_56, FT_57: unit_of = 6'd28;
            FT_60: unit_of = 6'd29;
            FT_62: unit_of = 6'd30;
            FT_68: unit_of = 6'd31;
            FT_70: unit_of = 6'd32;
            default: unit_of = 6'd0;
        endcase
    endfunction

    function automatic logic [3:0] state_code(input logic [7:0] b);
        case (b)
            8'h00: state_code = 4'd1;
            8'h02: state_code = 4'd2;
            8'h05: state_code = 4'd3;
            8'h06: state_code = 4'd4;
            8'h07: state_code = 4'd5;
            8'h08: state_code = 4'd6;
            8'h09: state_code = 4'd7;
            8'h0E: state_code = 4'd8;
            8'h10: state_code = 4'd9;
            8'hD6: state_code = 4'd10;
            8'hD7: state_code = 4'd11;
            8'hD9: state_code = 4'd12;
            8'hEB: state_code = 4'd13;
            default: state_code = TXT_RAW;
        endcase
    endfunction

endpackage

FILE: rtl/core/measuring_block_value_decoder.sv
// Top level of the measuring block value decoder: decode, scaling, division and output stages.
//
// Usage: drive func, byte_a and byte_b together with start. A transfer takes
// place at each rising edge where start is high and busy is low; busy is
// always low, so one triplet may be taken in every clock cycle.
// Each triplet yields exactly one result, presented on the o_ ports for a
// single cycle with o_strobe high, once it has passed through every stage.
// Results leave in the order the triplets came in.
// The pipeline is: one decode stage (a shared 8x10 product and formula
// selection), one scaling stage (an 18x21 multiply-add), one stage that
// takes the magnitude and prepares round-to-nearest, 28 divider stages
// producing one quotient bit each, a sign/offset stage and an output stage
// that applies the final times-1000 scaling. The 28-stage divider sets the
// latency; throughput is one triplet per cycle.
// A synchronous active-low reset clears all valid bits, so no strobe is
// produced for work that was in flight. The receiver cannot hold results
// off: every result is taken in the cycle it is shown.
module measuring_block_value_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         i_func,
    input  logic [7:0]         i_byte_a,
    input  logic [7:0]         i_byte_b,
    output logic               o_strobe,
    output logic [2:0]         o_kind,
    output logic signed [28:0] o_value_milli,
    output logic [1:0]         o_decimals,
    output logic [5:0]         o_unit,
    output logic [3:0]         o_text_code,
    output logic [7:0]         o_out_a,
    output logic [7:0]         o_out_b
);

    localparam int QW = mbvd_pkg::QW;
    localparam int MW = mbvd_pkg::MW;
    localparam int DW = mbvd_pkg::DW;

    assign busy = 1'b0;

    // ---------------- Stage 1: decode ----------------
    logic signed [9:0]  n_y;
    logic signed [18:0] n_pr;
    logic signed [17:0] n_x;
    logic [19:0]        n_k;
    logic signed [23:0] n_c;
    logic [15:0]        n_d;
    logic               n_rnd;
    mbvd_pkg::t_side    n_side;
    logic signed [17:0] w_w;
    logic signed [9:0]  w_sb;

    always_comb begin
        case (i_func)
            mbvd_pkg::FT_4:
                n_y = (i_byte_b > 8'd127) ? 10'(i_byte_b) - 10'sd127 : 10'sd127 - 10'(i_byte_b);
            mbvd_pkg::FT_5: n_y = 10'(i_byte_b) - 10'sd100;
            mbvd_pkg::FT_9, mbvd_pkg::FT_13, mbvd_pkg::FT_65: n_y = 10'(i_byte_b) - 10'sd127;
            mbvd_pkg::FT_27:
                n_y = (i_byte_b > 8'd128) ? 10'(i_byte_b) - 10'sd128 : 10'sd128 - 10'(i_byte_b);
            mbvd_pkg::FT_11, mbvd_pkg::FT_20, mbvd_pkg::FT_34, mbvd_pkg::FT_38,
            mbvd_pkg::FT_47, mbvd_pkg::FT_51: n_y = 10'(i_byte_b) - 10'sd128;
            default: n_y = 10'(i_byte_b);
        endcase
        n_pr = $signed({1'b0, i_byte_a}) * n_y;
    end

    assign w_w  = $signed({2'b00, i_byte_a, i_byte_b});
    assign w_sb = 10'(i_byte_b) - 10'sd128;

    always_comb begin
        n_x   = '0;
        n_k   = 20'd1;
        n_c   = '0;
        n_d   = 16'd1;
        n_rnd = 1'b0;
        n_side.kind  = mbvd_pkg::KIND_NUM;
        n_side.dec   = 2'd0;
        n_side.unit  = mbvd_pkg::unit_of(i_func);
        n_side.text  = mbvd_pkg::TXT_RAW;
        n_side.a     = i_byte_a;
        n_side.b     = i_byte_b;
        n_side.neg   = 1'b0;
        n_side.m1000 = 1'b0;
        n_side.offs  = '0;
        case (i_func)
            // Integer formulas: truncated quotient, then times 1000.
            mbvd_pkg::FT_1: begin
                n_x = 18'(n_pr); n_d = 16'd5; n_side.m1000 = 1'b1;
            end
            mbvd_pkg::FT_4, mbvd_pkg::FT_7: begin
                n_x = 18'(n_pr); n_d = 16'd100; n_side.m1000 = 1'b1;
            end
            mbvd_pkg::FT_5: begin
                n_x = 18'(n_pr); n_d = 16'd10; n_side.m1000 = 1'b1;
            end
            mbvd_pkg::FT_18: begin
                n_x = 18'(n_pr); n_d = 16'd25; n_side.m1000 = 1'b1;
            end
            mbvd_pkg::FT_26, mbvd_pkg::FT_28: begin
                n_x = 18'(i_byte_b) - 18'(i_byte_a); n_side.m1000 = 1'b1;
            end
            mbvd_pkg::FT_33: begin
                // A zero divisor falls back to the undivided value.
                n_x = 18'(i_byte_b) * 18'sd100; n_side.m1000 = 1'b1;
                n_d = (i_byte_a == 8'd0) ? 16'd1 : 16'(i_byte_a);
            end
            mbvd_pkg::FT_47: begin
                n_x = 18'(n_pr); n_k = 20'd1000;
            end
            mbvd_pkg::FT_48, mbvd_pkg::FT_54, mbvd_pkg::FT_56: begin
                n_x = w_w; n_k = 20'd1000;
            end
            mbvd_pkg::FT_52: begin
                n_x = 18'(n_pr); n_d = 16'd50; n_side.m1000 = 1'b1;
                n_side.offs = -$signed({1'b0, i_byte_a});
            end
            mbvd_pkg::FT_64: begin
                n_x = 18'(i_byte_a) + 18'(i_byte_b); n_k = 20'd1000;
            end
            // Exact scaled formulas.
            mbvd_pkg::FT_2, mbvd_pkg::FT_3: begin
                n_x = 18'(n_pr); n_k = 20'd2; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_6, mbvd_pkg::FT_12, mbvd_pkg::FT_21, mbvd_pkg::FT_22,
            mbvd_pkg::FT_24: begin
                n_x = 18'(n_pr); n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_45: begin
                n_x = 18'(n_pr); n_side.dec = 2'd3;
            end
            mbvd_pkg::FT_8: begin
                n_x = 18'(n_pr); n_k = 20'd100; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_9: begin
                n_x = 18'(n_pr); n_k = 20'd20; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_13, mbvd_pkg::FT_38: begin
                n_x = 18'(n_pr); n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_14, mbvd_pkg::FT_55: begin
                n_x = 18'(n_pr); n_k = 20'd5; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_15, mbvd_pkg::FT_19: begin
                n_x = 18'(n_pr); n_k = 20'd10; n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_27, mbvd_pkg::FT_34, mbvd_pkg::FT_35: begin
                n_x = 18'(n_pr); n_k = 20'd10; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_43: begin
                n_x = 18'(i_byte_a); n_k = 20'd25500; n_side.dec = 2'd2;
                n_c = 24'(i_byte_b) * 24'sd100;
            end
            mbvd_pkg::FT_49: begin
                n_x = 18'(n_pr); n_k = 20'd25; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_60: begin
                n_x = w_w; n_k = 20'd10; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_62: begin
                n_x = 18'(n_pr); n_k = 20'd256; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_65: begin
                n_x = 18'(n_pr); n_k = 20'd10; n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_67: begin
                n_x = 18'(i_byte_a); n_k = 20'd640000; n_side.dec = 2'd1;
                n_c = 24'(i_byte_b) * 24'sd2500;
            end
            mbvd_pkg::FT_70: begin
                n_x = w_w; n_k = 20'd192; n_side.dec = 2'd2;
            end
            // Rounded formulas: nearest, ties away from zero.
            mbvd_pkg::FT_11: begin
                n_x = 18'(n_pr) + 18'sd10000; n_d = 16'd10; n_rnd = 1'b1; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_20: begin
                n_x = 18'(n_pr); n_k = 20'd1000; n_d = 16'd128; n_rnd = 1'b1;
                n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_23, mbvd_pkg::FT_39: begin
                n_x = 18'(n_pr); n_k = 20'd1000; n_d = 16'd256; n_rnd = 1'b1;
                n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_25: begin
                // 1421 * b * 182 folded into one constant.
                n_x = 18'(i_byte_b); n_k = 20'd258622; n_d = 16'd182; n_rnd = 1'b1;
                n_c = 24'(i_byte_a) * 24'sd1000; n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_30: begin
                n_x = 18'(n_pr); n_k = 20'd1000; n_d = 16'd12; n_rnd = 1'b1;
                n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_31: begin
                n_x = 18'(n_pr); n_k = 20'd1000; n_d = 16'd2560; n_rnd = 1'b1;
                n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_46: begin
                n_x = 18'(n_pr) - 18'sd3200; n_k = 20'd27; n_d = 16'd10; n_rnd = 1'b1;
                n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_50: begin
                n_x = 18'(w_sb); n_k = 20'd100000; n_rnd = 1'b1; n_side.dec = 2'd1;
                n_d = (i_byte_a == 8'd0) ? 16'd1 : 16'(i_byte_a);
            end
            mbvd_pkg::FT_51: begin
                n_x = 18'(n_pr); n_k = 20'd1000; n_d = 16'd255; n_rnd = 1'b1;
                n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_53: begin
                n_x = 18'(w_sb); n_k = 20'd14222; n_d = 16'd10; n_rnd = 1'b1;
                n_c = 24'(i_byte_a) * 24'sd60; n_side.dec = 2'd1;
            end
            mbvd_pkg::FT_59: begin
                n_x = w_w; n_k = 20'd1000; n_d = 16'd32768; n_rnd = 1'b1;
                n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_61: begin
                n_x = 18'(w_sb); n_k = 20'd1000; n_rnd = 1'b1; n_side.dec = 2'd2;
                n_d = (i_byte_a == 8'd0) ? 16'd1 : 16'(i_byte_a);
            end
            mbvd_pkg::FT_66: begin
                n_x = 18'(n_pr); n_k = 20'd100000; n_d = 16'd51112; n_rnd = 1'b1;
                n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_68: begin
                // 1000000 / 7365 reduced to 200000 / 1473.
                n_x = w_w; n_k = 20'd200000; n_d = 16'd1473; n_rnd = 1'b1;
                n_side.dec = 2'd2;
            end
            mbvd_pkg::FT_69: begin
                n_x = w_w; n_k = 20'd3254; n_d = 16'd10; n_rnd = 1'b1;
                n_side.dec = 2'd2;
            end
            // Pass-through kinds carry a zero value.
            mbvd_pkg::FT_10: begin
                n_side.kind = mbvd_pkg::KIND_TEXT;
                n_side.text = (i_byte_b == 8'd0) ? mbvd_pkg::TXT_COLD : mbvd_pkg::TXT_WARM;
            end
            mbvd_pkg::FT_37: begin
                n_side.kind = mbvd_pkg::KIND_TEXT;
                n_side.text = mbvd_pkg::state_code(i_byte_b);
            end
            mbvd_pkg::FT_16: n_side.kind = mbvd_pkg::KIND_BITS;
            mbvd_pkg::FT_17: n_side.kind = mbvd_pkg::KIND_CHR2;
            mbvd_pkg::FT_63: n_side.kind = mbvd_pkg::KIND_CHRQ;
            mbvd_pkg::FT_44: n_side.kind = mbvd_pkg::KIND_HM;
            default: n_side.kind = mbvd_pkg::KIND_UNK;
        endcase
    end

    logic               r_v1;
    logic signed [17:0] r_x;
    logic [19:0]        r_k;
    logic signed [23:0] r_c;
    logic [15:0]        r_d1;
    logic               r_rnd1;
    mbvd_pkg::t_side    r_side1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
        r_x     <= n_x;
        r_k     <= n_k;
        r_c     <= n_c;
        r_d1    <= n_d;
        r_rnd1  <= n_rnd;
        r_side1 <= n_side;
    end

    // ---------------- Stage 2: scaling multiply-add ----------------
    logic                  r_v2;
    logic signed [MW-1:0]  r_n;
    logic [15:0]           r_d2;
    logic                  r_rnd2;
    mbvd_pkg::t_side       r_side2;
    logic signed [MW-1:0]  n_prod;

    assign n_prod = r_x * $signed({1'b0, r_k});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_n     <= n_prod + MW'(r_c);
        r_d2    <= r_d1;
        r_rnd2  <= r_rnd1;
        r_side2 <= r_side1;
    end

    // ---------------- Stage 3: magnitude and rounding bias ----------------
    // Rounding to nearest is floor((2|n| + d) / 2d); truncation is floor(|n| / d).
    logic                  r_v3;
    logic [MW-1:0]         r_num;
    logic [DW-1:0]         r_den;
    mbvd_pkg::t_side       r_side3;
    logic [MW-1:0]         n_mag;
    mbvd_pkg::t_side       n_side3;

    always_comb begin
        n_mag        = r_n[MW-1] ? MW'(-r_n) : MW'(r_n);
        n_side3      = r_side2;
        n_side3.neg  = r_n[MW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_num   <= r_rnd2 ? {n_mag[MW-2:0], 1'b0} + MW'(r_d2) : n_mag;
        r_den   <= r_rnd2 ? {r_d2, 1'b0} : {1'b0, r_d2};
        r_side3 <= n_side3;
    end

    // ---------------- Divider ----------------
    logic              w_dv;
    logic [QW-1:0]     w_quo;
    mbvd_pkg::t_side   w_dside;

    mbvd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_side3),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_dside)
    );

    // ---------------- Post stage: sign and offset ----------------
    logic                r_v4;
    logic signed [29:0]  r_t;
    mbvd_pkg::t_side     r_side4;
    logic signed [29:0]  n_sq;

    assign n_sq = w_dside.neg ? -$signed({2'b00, w_quo}) : $signed({2'b00, w_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= w_dv;
        end
        r_t     <= n_sq + 30'(w_dside.offs);
        r_side4 <= w_dside;
    end

    // ---------------- Output stage ----------------
    logic signed [40:0] n_scaled;

    assign n_scaled = r_side4.m1000 ? r_t * 41'sd1000 : 41'(r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_v4;
        end
        o_kind        <= r_side4.kind;
        o_value_milli <= n_scaled[28:0];
        o_decimals    <= r_side4.dec;
        o_unit        <= r_side4.unit;
        o_text_code   <= r_side4.text;
        o_out_a       <= r_side4.a;
        o_out_b       <= r_side4.b;
    end

    a_nonnum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind != mbvd_pkg::KIND_NUM) |-> (o_value_milli == '0 && o_decimals == '0))
        else $error("non-numeric result carries a value or decimals");

    a_text_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_text_code != mbvd_pkg::TXT_RAW) |-> (o_kind == mbvd_pkg::KIND_TEXT))
        else $error("text code on a result that is not text");

    a_hm_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == mbvd_pkg::KIND_HM) |-> (o_unit == mbvd_pkg::UNIT_HM))
        else $error("hours:minutes result with wrong unit");

endmodule

FILE: rtl/core/mbvd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with side data carried along.
module mbvd_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [mbvd_pkg::MW-1:0]  i_num,
    input  logic [mbvd_pkg::DW-1:0]  i_den,
    input  mbvd_pkg::t_side          i_side,
    output logic                     o_valid,
    output logic [mbvd_pkg::QW-1:0]  o_quo,
    output mbvd_pkg::t_side          o_side
);

    localparam int QW = mbvd_pkg::QW;
    localparam int DW = mbvd_pkg::DW;
    localparam int MW = mbvd_pkg::MW;

    logic                r_vld  [1:QW];
    logic [DW-1:0]       r_rem  [1:QW];
    logic [QW-1:0]       r_lo   [1:QW];
    logic [DW-1:0]       r_den  [1:QW];
    mbvd_pkg::t_side     r_side [1:QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic              w_vld;
        logic [DW-1:0]     w_rem;
        logic [QW-1:0]     w_lo;
        logic [DW-1:0]     w_den;
        mbvd_pkg::t_side   w_side;
        logic [DW:0]       n_trial;
        logic              n_ge;
        logic [DW:0]       n_diff;

        if (g == 0) begin : g_head
            // The first stage starts from the upper dividend bits, which are
            // below the divisor because the quotient fits in QW bits.
            assign w_vld  = i_valid;
            assign w_rem  = DW'(i_num[MW-1:QW]);
            assign w_lo   = i_num[QW-1:0];
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[g];
            assign w_rem  = r_rem[g];
            assign w_lo   = r_lo[g];
            assign w_den  = r_den[g];
            assign w_side = r_side[g];
        end

        always_comb begin
            n_trial = {w_rem, w_lo[QW-1]};
            n_ge    = (n_trial >= {1'b0, w_den});
            n_diff  = n_trial - {1'b0, w_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= w_vld;
            end
            r_rem[g+1]  <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_lo[g+1]   <= {w_lo[QW-2:0], n_ge};
            r_den[g+1]  <= w_den;
            r_side[g+1] <= w_side;
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_lo[QW];
    assign o_side  = r_side[QW];

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_den != '0))
        else $error("divider fed a zero divisor");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW] |-> (r_rem[QW] < r_den[QW]))
        else $error("final remainder not below divisor");

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the measuring block value decoder.
`timescale 1ns / 100ps

module tb;

    // One decoded measurement as the block presents it.
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [28:0] value;
        logic [1:0]         dec;
        logic [5:0]         unit;
        logic [3:0]         text;
        logic [7:0]         a;
        logic [7:0]         b;
    } t_reading;

    // One measurement triplet on its way into the block.
    typedef struct packed {
        logic [7:0] func;
        logic [7:0] a;
        logic [7:0] b;
    } t_triplet;

    localparam int LATENCY = 33;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [7:0]         i_func = '0;
    logic [7:0]         i_byte_a = '0;
    logic [7:0]         i_byte_b = '0;
    logic               o_strobe;
    logic [2:0]         o_kind;
    logic signed [28:0] o_value_milli;
    logic [1:0]         o_decimals;
    logic [5:0]         o_unit;
    logic [3:0]         o_text_code;
    logic [7:0]         o_out_a;
    logic [7:0]         o_out_b;

    measuring_block_value_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_byte_a      (i_byte_a),
        .i_byte_b      (i_byte_b),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_value_milli (o_value_milli),
        .o_decimals    (o_decimals),
        .o_unit        (o_unit),
        .o_text_code   (o_text_code),
        .o_out_a       (o_out_a),
        .o_out_b       (o_out_b)
    );

    always #2 i_clk = ~i_clk;

    t_triplet pending_triplets[$];
    t_reading expected_readings[$];
    int       mismatch_count = 0;
    bit       stim_done = 1'b0;
    bit       quiet_tail = 1'b0;
    int       idle_left = 0;

    // Rounds n/d to nearest, ties away from zero; d is positive.
    function automatic longint div_round(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (2 * mag + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    // Unit code of a formula type, written as its own table.
    function automatic logic [5:0] unit_code(logic [7:0] f);
        case (f)
            1: return 6'd1;
            2, 20, 23, 33: return 6'd2;
            3, 9, 27, 34, 67: return 6'd3;
            5, 31: return 6'd4;
            6, 21, 43, 66: return 6'd5;
            7: return 6'd6;
            12, 64: return 6'd7;
            13, 65: return 6'd8;
            14, 69: return 6'd9;
            15, 22, 47: return 6'd10;
            16: return 6'd11;
            18, 50: return 6'd12;
            19: return 6'd13;
            24, 40: return 6'd14;
            25, 53: return 6'd15;
            26: return 6'd16;
            35: return 6'd17;
            36: return 6'd18;
            37: return 6'd19;
            30, 38, 46: return 6'd20;
            41: return 6'd21;
            42: return 6'd22;
            44: return mbvd_pkg::UNIT_HM;
            39, 49, 51: return 6'd24;
            52: return 6'd25;
            54: return 6'd26;
            55: return 6'd27;
            56, 57: return 6'd28;
            60: return 6'd29;
            62: return 6'd30;
            68: return 6'd31;
            70: return 6'd32;
            default: return 6'd0;
        endcase
    endfunction

    // Text code of a raw state byte for the state formula.
    function automatic logic [3:0] state_text(logic [7:0] b);
        case (b)
            8'h00: return 4'd1;
            8'h02: return 4'd2;
            8'h05: return 4'd3;
            8'h06: return 4'd4;
            8'h07: return 4'd5;
            8'h08: return 4'd6;
            8'h09: return 4'd7;
            8'h0E: return 4'd8;
            8'h10: return 4'd9;
            8'hD6: return 4'd10;
            8'hD7: return 4'd11;
            8'hD9: return 4'd12;
            8'hEB: return 4'd13;
            default: return mbvd_pkg::TXT_RAW;
        endcase
    endfunction

    // Decodes one triplet the way the block should. Integer formulas use
    // truncating division at full width; fractional ones round to thousandths.
    function automatic t_reading decode_triplet(t_triplet t);
        t_reading r;
        longint a;
        longint b;
        longint p;
        longint w;
        longint v;
        a = t.a;
        b = t.b;
        p = a * b;
        w = 256 * a + b;
        v = 0;
        r = '0;
        r.kind = mbvd_pkg::KIND_NUM;
        case (t.func)
            1:  v = (p / 5) * 1000;
            4:  v = ((((b > 127) ? b - 127 : 127 - b) * a) / 100) * 1000;
            5:  v = ((a * (b - 100)) / 10) * 1000;
            7:  v = (p / 100) * 1000;
            18: v = (p / 25) * 1000;
            26, 28: v = (b - a) * 1000;
            33: v = ((a == 0) ? 100 * b : (100 * b) / a) * 1000;
            47: v = (b - 128) * a * 1000;
            48, 54, 56: v = w * 1000;
            52: v = (p / 50 - a) * 1000;
            64: v = (a + b) * 1000;
            2, 3: begin v = p * 2; r.dec = 2'd1; end
            6, 12, 21, 22, 24: begin v = p; r.dec = 2'd2; end
            8:  begin v = p * 100; r.dec = 2'd1; end
            9:  begin v = (b - 127) * a * 20; r.dec = 2'd1; end
            11: begin v = div_round(a * (b - 128) + 10000, 10); r.dec = 2'd1; end
            13: begin v = (b - 127) * a; r.dec = 2'd1; end
            14: begin v = p * 5; r.dec = 2'd1; end
            15, 19: begin v = p * 10; r.dec = 2'd2; end
            20: begin v = div_round(a * (b - 128) * 1000, 128); r.dec = 2'd2; end
            23, 39: begin v = div_round(p * 1000, 256); r.dec = 2'd1; end
            25: begin v = div_round(a * 1000 + 1421 * b * 182, 182); r.dec = 2'd2; end
            27: begin v = ((b > 128) ? b - 128 : 128 - b) * a * 10; r.dec = 2'd1; end
            30: begin v = div_round(p * 1000, 12); r.dec = 2'd1; end
            31: begin v = div_round(p * 1000, 2560); r.dec = 2'd1; end
            34: begin v = (b - 128) * a * 10; r.dec = 2'd1; end
            35: begin v = p * 10; r.dec = 2'd1; end
            38: begin v = (b - 128) * a; r.dec = 2'd1; end
            43: begin v = b * 100 + a * 25500; r.dec = 2'd2; end
            45: begin v = p; r.dec = 2'd3; end
            46: begin v = div_round((p - 3200) * 27, 10); r.dec = 2'd1; end
            49: begin v = p * 25; r.dec = 2'd1; end
            50: begin
                v = (a == 0) ? (b - 128) * 100000 : div_round((b - 128) * 100000, a);
                r.dec = 2'd1;
            end
            51: begin v = div_round((b - 128) * a * 1000, 255); r.dec = 2'd1; end
            53: begin v = div_round((b - 128) * 14222 + a * 60, 10); r.dec = 2'd1; end
            55: begin v = p * 5; r.dec = 2'd1; end
            59: begin v = div_round(w * 1000, 32768); r.dec = 2'd2; end
            60: begin v = w * 10; r.dec = 2'd1; end
            61: begin
                v = (a == 0) ? (b - 128) * 1000 : div_round((b - 128) * 1000, a);
                r.dec = 2'd2;
            end
            62: begin v = p * 256; r.dec = 2'd1; end
            65: begin v = a * (b - 127) * 10; r.dec = 2'd2; end
            66: begin v = div_round(p * 100000, 51112); r.dec = 2'd2; end
            67: begin v = a * 640000 + b * 2500; r.dec = 2'd1; end
            68: begin v = div_round(w * 1000000, 7365); r.dec = 2'd2; end
            69: begin v = div_round(w * 3254, 10); r.dec = 2'd2; end
            70: begin v = w * 192; r.dec = 2'd2; end
            10: begin
                r.kind = mbvd_pkg::KIND_TEXT;
                r.text = (b == 0) ? mbvd_pkg::TXT_COLD : mbvd_pkg::TXT_WARM;
            end
            37: begin r.kind = mbvd_pkg::KIND_TEXT; r.text = state_text(t.b); end
            16: r.kind = mbvd_pkg::KIND_BITS;
            17: r.kind = mbvd_pkg::KIND_CHR2;
            63: r.kind = mbvd_pkg::KIND_CHRQ;
            44: r.kind = mbvd_pkg::KIND_HM;
            default: r.kind = mbvd_pkg::KIND_UNK;
        endcase
        r.value = v[28:0];
        r.unit = unit_code(t.func);
        r.a = t.a;
        r.b = t.b;
        return r;
    endfunction

    function automatic t_triplet make_triplet(int f, int a, int b);
        t_triplet t;
        t.func = f[7:0];
        t.a = a[7:0];
        t.b = b[7:0];
        return t;
    endfunction

    // Driver: a transfer happens at an edge where start is high and busy low.
    // After an accepted transfer the next item is loaded or start drops, with
    // exactly one assignment to start per edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(start && busy)) begin
                if (start)
                    expected_readings.push_back(
                        decode_triplet(make_triplet(i_func, i_byte_a, i_byte_b)));
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                    start <= 1'b0;
                end else if (pending_triplets.size() > 0 &&
                             (quiet_tail || $urandom_range(0, 5) != 0)) begin
                    t_triplet t;
                    t = pending_triplets.pop_front();
                    i_func <= t.func;
                    i_byte_a <= t.a;
                    i_byte_b <= t.b;
                    start <= 1'b1;
                end else begin
                    if (pending_triplets.size() > 0)
                        idle_left <= $urandom_range(0, 2);
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_reading got;
            t_reading exp_r;
            got = {o_kind, o_value_milli, o_decimals, o_unit, o_text_code, o_out_a, o_out_b};
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result with nothing outstanding: %p", got);
            end else begin
                exp_r = expected_readings.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: a=%0d b=%0d expected %p got %p",
                                 exp_r.a, exp_r.b, exp_r, got);
                end
            end
        end
    end

    // Stimulus: directed corners first, then mostly known formula types.
    initial begin
        int dir_funcs[$];
        int f;
        dir_funcs = '{1, 4, 5, 7, 18, 26, 28, 33, 47, 48, 52, 54, 56, 64, 2, 3, 6, 8, 9,
                      11, 12, 13, 14, 15, 19, 20, 21, 22, 23, 24, 25, 27, 30, 31, 34,
                      35, 38, 39, 43, 45, 46, 49, 50, 51, 53, 55, 59, 60, 61, 62, 65,
                      66, 67, 68, 69, 70, 10, 37, 16, 17, 63, 44, 36, 40, 41, 42, 57,
                      0, 29, 32, 58, 71, 255};
        // Zero divisors, the corrected divide of type 59, both temperature states,
        // unknown types and the all-zero and all-one byte corners.
        pending_triplets.push_back(make_triplet(33, 0, 255));
        pending_triplets.push_back(make_triplet(50, 0, 0));
        pending_triplets.push_back(make_triplet(61, 0, 255));
        pending_triplets.push_back(make_triplet(59, 255, 255));
        pending_triplets.push_back(make_triplet(10, 7, 0));
        pending_triplets.push_back(make_triplet(10, 7, 1));
        pending_triplets.push_back(make_triplet(37, 1, 8'hEB));
        pending_triplets.push_back(make_triplet(37, 1, 8'h01));
        pending_triplets.push_back(make_triplet(67, 255, 255));
        pending_triplets.push_back(make_triplet(47, 255, 0));
        pending_triplets.push_back(make_triplet(68, 255, 255));
        pending_triplets.push_back(make_triplet(46, 0, 0));
        pending_triplets.push_back(make_triplet(255, 255, 255));
        pending_triplets.push_back(make_triplet(0, 0, 0));
        pending_triplets.push_back(make_triplet(53, 0, 0));
        // Every formula type with edge bytes.
        foreach (dir_funcs[i]) begin
            case ($urandom_range(0, 3))
                0: pending_triplets.push_back(make_triplet(dir_funcs[i], 0, 0));
                1: pending_triplets.push_back(make_triplet(dir_funcs[i], 255, 255));
                2: pending_triplets.push_back(make_triplet(dir_funcs[i], 255, 0));
                default: pending_triplets.push_back(make_triplet(dir_funcs[i], 1, 128));
            endcase
        end
        for (int n = 0; n < 1200; n++) begin
            if ($urandom_range(0, 9) < 8)
                f = dir_funcs[$urandom_range(0, dir_funcs.size() - 1)];
            else
                f = $urandom_range(0, 255);
            case ($urandom_range(0, 7))
                0: pending_triplets.push_back(make_triplet(f, 0, $urandom_range(0, 255)));
                1: pending_triplets.push_back(make_triplet(f, $urandom_range(0, 255),
                                                           (n % 2) ? 255 : 0));
                default: pending_triplets.push_back(
                    make_triplet(f, $urandom_range(0, 255), $urandom_range(0, 255)));
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The last stretch of items is fed without gaps.
        wait (pending_triplets.size() < 150);
        @(posedge i_clk);
        quiet_tail <= 1'b1;
        wait (pending_triplets.size() == 0);
        @(posedge i_clk);
        while (start) @(posedge i_clk);
        while (expected_readings.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Timeout: far beyond the slowest correct run.
    initial begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
